/* rtl/core/swcd_pkg.sv */
// shared constants, codes and types of the sparse weighted column dot core
package swcd_pkg;

	localparam int ROW_COUNT     = 1024;
	localparam int VALUE_WIDTH   = 16;
	localparam int ROW_FIELD_W   = 10;
	localparam int VALUE_FIELD_W = 16;
	localparam int SUM_W         = 56;
	localparam int INDEX_W       = 16;
	localparam int TAG_W         = 16;
	localparam int ROW_AW        = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int PROD_WA_W     = 2 * VALUE_WIDTH;
	localparam int PROD_W        = 3 * VALUE_WIDTH;
	localparam int ADD_W         = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
	localparam int ENTRY_W       = TAG_W + VALUE_WIDTH;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// request kinds on the input channel
	typedef enum logic [1:0] {
		REQ_WEIGHT = 2'd0,
		REQ_A      = 2'd1,
		REQ_B      = 2'd2,
		REQ_CLOSE  = 2'd3
	} req_kind_t;

	// tag store sequencer
	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} clr_state_t;

	// item handed from the store stage to the multiply-accumulate stages
	typedef struct packed {
		logic                          is_b;
		logic                          is_close;
		logic                          hit;
		logic signed [VALUE_WIDTH-1:0] w;
		logic signed [VALUE_WIDTH-1:0] a;
		logic signed [VALUE_WIDTH-1:0] b;
	} item_t;

endpackage

/* rtl/core/swcd_in_if.sv */
// request channel interface: kind, row and value of one item
interface swcd_in_if import swcd_pkg::*; ();
	logic                            valid;
	logic                            ready;
	logic [1:0]                      req_type;
	logic [ROW_FIELD_W-1:0]          row;
	logic signed [VALUE_FIELD_W-1:0] value;

	modport source (output valid, output req_type, output row, output value, input ready);
	modport sink (input valid, input req_type, input row, input value, output ready);
endinterface

/* rtl/core/swcd_out_if.sv */
// result channel interface: column sum and column index
interface swcd_out_if import swcd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] column_sum;
	logic [INDEX_W-1:0]      column_index;

	modport source (output valid, output column_sum, output column_index, input ready);
	modport sink (input valid, input column_sum, input column_index, output ready);
endinterface

/* rtl/core/swcd_store.sv */
// weight and entry memories, column tag, tag clear sequencer and read stage
module swcd_store import swcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	swcd_in_if.sink    req,
	input  logic       advance,
	output item_t      item_s1
);

	logic signed [VALUE_WIDTH-1:0] weight_mem [ROW_COUNT];
	logic [ENTRY_W-1:0]            entry_mem [ROW_COUNT];

	clr_state_t                    state_q;
	clr_state_t                    state_d;
	logic                          clearing;
	logic [ROW_AW-1:0]             clr_cnt_q;
	logic [TAG_W-1:0]              tag_q;

	req_kind_t                     kind;
	logic                          accept;
	logic                          in_range;
	logic [ROW_AW-1:0]             addr;
	logic signed [VALUE_WIDTH-1:0] vbits;
	logic                          wr_w;
	logic                          wr_a;
	logic                          rd_b;
	logic                          close_acc;

	logic                          is_b_s1;
	logic                          is_close_s1;
	logic signed [VALUE_WIDTH-1:0] w_rd_s1;
	logic [ENTRY_W-1:0]            entry_rd_s1;
	logic signed [VALUE_WIDTH-1:0] b_s1;
	logic [TAG_W-1:0]              tag_s1;

	// request decode
	assign req.ready = advance && !clearing;
	assign accept    = req.valid && req.ready;
	assign kind      = req_kind_t'(req.req_type);
	assign in_range  = 32'(req.row) < 32'(ROW_COUNT);
	assign addr      = ROW_AW'(req.row);
	assign vbits     = VALUE_WIDTH'($unsigned(req.value));
	assign wr_w      = accept && in_range && (kind == REQ_WEIGHT);
	assign wr_a      = accept && in_range && (kind == REQ_A);
	assign rd_b      = accept && in_range && (kind == REQ_B);
	assign close_acc = accept && (kind == REQ_CLOSE);

	// weight memory
	always_ff @(posedge clk) begin
		if (wr_w) begin
			weight_mem[addr] <= vbits;
		end
		if (rd_b) begin
			w_rd_s1 <= weight_mem[addr];
		end
	end

	// entry memory: tag and first-matrix value per row
	always_ff @(posedge clk) begin
		if (clearing) begin
			entry_mem[clr_cnt_q] <= '0;
		end else if (wr_a) begin
			entry_mem[addr] <= {tag_q, vbits};
		end
		if (rd_b) begin
			entry_rd_s1 <= entry_mem[addr];
		end
	end

	// clear sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == ROW_AW'(ROW_COUNT - 1)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (close_acc && (tag_q == '1)) begin
					state_d = ST_CLEAR;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// clear sequencer outputs
	always_comb begin
		case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_RUN:   clearing = 1'b0;
			default:  clearing = 1'b1;
		endcase
	end

	// sequencer state, clear address and column tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			tag_q     <= TAG_W'(1);
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end else begin
				clr_cnt_q <= '0;
			end
			if (close_acc) begin
				tag_q <= (tag_q == '1) ? TAG_W'(1) : tag_q + 1'b1;
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_b_s1     <= 1'b0;
			is_close_s1 <= 1'b0;
		end else if (advance) begin
			is_b_s1     <= rd_b;
			is_close_s1 <= close_acc;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (rd_b) begin
			b_s1   <= vbits;
			tag_s1 <= tag_q;
		end
	end

	// hit when the stored entry carries the tag of the column it was read in
	assign item_s1.is_b     = is_b_s1;
	assign item_s1.is_close = is_close_s1;
	assign item_s1.hit      = entry_rd_s1[ENTRY_W-1 -: TAG_W] == tag_s1;
	assign item_s1.w        = w_rd_s1;
	assign item_s1.a        = entry_rd_s1[VALUE_WIDTH-1:0];
	assign item_s1.b        = b_s1;

`ifndef SYNTHESIS
	// tag zero marks cleared entries and is never a live column
	a_tag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tag_q != '0)
		else $error("column tag reached zero");

	// a wrapping close restarts the tag at one and starts a clear pass
	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		close_acc && (tag_q == '1) |=> (tag_q == TAG_W'(1)) && clearing)
		else $error("tag wrap did not restart tag and clear");

	// the clear pass runs until the last row is written
	a_clear_length: assert property (@(posedge clk) disable iff (!arst_n)
		clearing && (clr_cnt_q != ROW_AW'(ROW_COUNT - 1)) |=> clearing)
		else $error("clear pass ended early");
`endif

endmodule

/* rtl/core/swcd_mac.sv */
// weight-entry products, saturating accumulator and result register
module swcd_mac import swcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item_s1,
	output logic       advance,
	swcd_out_if.source rsp
);

	logic                          add_s2;
	logic                          is_close_s2;
	logic signed [PROD_WA_W-1:0]   prod_wa_s2;
	logic signed [VALUE_WIDTH-1:0] b_s2;
	logic                          add_s3;
	logic                          is_close_s3;
	logic signed [PROD_W-1:0]      prod_s3;

	logic signed [SUM_W-1:0]       running_sum_q;
	logic [INDEX_W-1:0]            closed_q;
	logic                          out_valid_q;
	logic signed [SUM_W-1:0]       out_sum_q;
	logic [INDEX_W-1:0]            out_idx_q;

	logic signed [ADD_W-1:0]       sum_ext;
	logic signed [SUM_W-1:0]       sat_sum;
	logic                          emit;

	// hold all stages while a close waits on a full result register
	assign advance = !(is_close_s3 && out_valid_q && !rsp.ready);
	assign emit    = advance && is_close_s3;

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s2      <= 1'b0;
			is_close_s2 <= 1'b0;
			add_s3      <= 1'b0;
			is_close_s3 <= 1'b0;
		end else if (advance) begin
			add_s2      <= item_s1.is_b && item_s1.hit;
			is_close_s2 <= item_s1.is_close;
			add_s3      <= add_s2;
			is_close_s3 <= is_close_s2;
		end
	end

	// weight times entry, then times second-matrix value
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_wa_s2 <= $signed(item_s1.w) * $signed(item_s1.a);
			b_s2       <= item_s1.b;
			prod_s3    <= prod_wa_s2 * b_s2;
		end
	end

	// saturating add onto the running sum
	always_comb begin
		sum_ext = ADD_W'(running_sum_q) + ADD_W'(prod_s3);
		if (sum_ext > ADD_W'(SUM_MAX)) begin
			sat_sum = SUM_MAX;
		end else if (sum_ext < ADD_W'(SUM_MIN)) begin
			sat_sum = SUM_MIN;
		end else begin
			sat_sum = sum_ext[SUM_W-1:0];
		end
	end

	// accumulator, column count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			closed_q      <= '0;
			out_valid_q   <= 1'b0;
		end else if (emit) begin
			running_sum_q <= '0;
			closed_q      <= closed_q + 1'b1;
			out_valid_q   <= 1'b1;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && add_s3) begin
				running_sum_q <= sat_sum;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_sum_q <= running_sum_q;
			out_idx_q <= closed_q + 1'b1;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.column_sum   = out_sum_q;
	assign rsp.column_index = out_idx_q;

endmodule

/* rtl/core/sparse_weighted_column_dot_core.sv */
// top level of the sparse weighted column dot core
// Takes one item per cycle: weight loads and first-matrix entries are written into
// their row-indexed memories at acceptance, and a second-matrix entry reads both
// memories in the same cycle, then passes through two multiply stages and a
// saturating accumulate. A close item follows the same three-stage path, so its
// result is loaded into the output register from the third stage and includes
// every entry given before it. The output register lets the next items enter
// while a result waits; outside a clear pass, input ready drops only when a later
// close reaches the accumulator before the previous result is taken. After reset
// and after every 65535th close, a clear pass writes the entry memory one row per
// cycle through all ROW_COUNT (1024) rows with input ready low.
module sparse_weighted_column_dot_core import swcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	swcd_in_if.sink    req,
	swcd_out_if.source rsp
);

	item_t item_s1;
	logic  advance;

	// memories, tag and read stage
	swcd_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.advance (advance),
		.item_s1 (item_s1)
	);

	// products, accumulator and result register
	swcd_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.advance (advance),
		.rsp     (rsp)
	);

endmodule
